>>> rtl/core/isdn_info_element_finder_defines.svh
// -----------------------------------------------------------------------------
// isdn_info_element_finder_defines.svh
// Assertion macros used by the element finder top level.
// -----------------------------------------------------------------------------
`ifndef ISDN_INFO_ELEMENT_FINDER_DEFINES_SVH
`define ISDN_INFO_ELEMENT_FINDER_DEFINES_SVH

// Same-cycle implication, sampled on the rising edge, off during reset.
`define IEF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising edge, off during reset.
`define IEF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/ief_pkg.sv
// -----------------------------------------------------------------------------
// ief_pkg
// Types and constants of the information element finder.
// -----------------------------------------------------------------------------
package ief_pkg;

    localparam int OFFSET_W          = 9;
    localparam int MAX_OFFSET        = 511;
    localparam int DEF_MAX_MSG_BYTES = 512;

    localparam logic [7:0] SHIFT_MASK   = 8'hf0;
    localparam logic [7:0] SHIFT_CODE   = 8'h90;
    localparam logic [7:0] CODESET_MASK = 8'h07;
    localparam logic [7:0] NONLOCK_BIT  = 8'h08;
    localparam logic [7:0] SINGLE_BIT   = 8'h80;
    localparam logic [7:0] CRLEN_MASK   = 8'h0f;

    typedef enum logic [1:0] {
        OUT_FOUND  = 2'd0,
        OUT_PASSED = 2'd1,
        OUT_END    = 2'd2
    } t_outcome;

    typedef struct packed {
        t_outcome              outcome;
        logic [OFFSET_W-1:0]   offset;
    } t_result;

    // handshake between the parse stage and the result register
    typedef struct packed {
        logic    load;
        t_result res;
    } t_result_req;

endpackage

>>> rtl/core/ief_in_if.sv
// -----------------------------------------------------------------------------
// ief_in_if
// Octet channel into the element finder.
// -----------------------------------------------------------------------------
interface ief_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] msg_byte;
    logic       last_byte;
    logic [7:0] wanted_ie;
    logic [2:0] wanted_codeset;

    modport source (
        output valid, msg_byte, last_byte, wanted_ie, wanted_codeset,
        input  ready
    );
    modport sink (
        input  valid, msg_byte, last_byte, wanted_ie, wanted_codeset,
        output ready
    );
endinterface

>>> rtl/core/ief_out_if.sv
// -----------------------------------------------------------------------------
// ief_out_if
// Search result channel out of the element finder.
// -----------------------------------------------------------------------------
interface ief_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] outcome;
    logic [8:0] ie_offset;

    modport source (
        output valid, outcome, ie_offset,
        input  ready
    );
    modport sink (
        input  valid, outcome, ie_offset,
        output ready
    );
endinterface

>>> rtl/core/ief_parser.sv
// -----------------------------------------------------------------------------
// ief_parser
// Input register and per-octet message walk; issues at most one result.
// -----------------------------------------------------------------------------
module ief_parser
    import ief_pkg::*;
#(
    parameter int MaxMsgBytes = DEF_MAX_MSG_BYTES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ief_in_if.sink        i_in,
    input  logic          i_space,
    output t_result_req   o_req
);

    localparam int PosCapInt = (MaxMsgBytes - 1 < MAX_OFFSET) ? MaxMsgBytes - 1 : MAX_OFFSET;
    localparam logic [OFFSET_W-1:0] POS_CAP = OFFSET_W'(PosCapInt);

    typedef enum logic [7:0] {
        PH_DISC  = 8'b0000_0001,
        PH_CRLEN = 8'b0000_0010,
        PH_CRREF = 8'b0000_0100,
        PH_MTYPE = 8'b0000_1000,
        PH_IDENT = 8'b0001_0000,
        PH_LEN   = 8'b0010_0000,
        PH_BODY  = 8'b0100_0000,
        PH_IDLE  = 8'b1000_0000
    } t_phase;

    // input register
    logic       r_s1_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic [7:0] r_wie;
    logic [2:0] r_wcs;

    // parse state
    t_phase              r_phase,  n_phase;
    logic [7:0]          r_skip,   n_skip;
    logic [2:0]          r_active, n_active;
    logic [2:0]          r_locked, n_locked;
    logic [OFFSET_W-1:0] r_pos,    n_pos;
    logic [7:0]          r_sie,    n_sie;
    logic [2:0]          r_scs,    n_scs;

    logic                advance;
    logic                have;
    t_outcome            outcome;
    logic [OFFSET_W-1:0] offset;
    logic [OFFSET_W-1:0] pos_cur;
    logic [2:0]          act_new;
    logic [2:0]          lock_new;
    logic [7:0]          skip_dec;
    logic                shift_hit;
    logic                cs_match;

    assign advance    = r_s1_valid && i_space;
    assign i_in.ready = !r_s1_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_byte <= i_in.msg_byte;
            r_last <= i_in.last_byte;
            r_wie  <= i_in.wanted_ie;
            r_wcs  <= i_in.wanted_codeset;
        end
    end

    assign pos_cur   = (r_phase == PH_DISC) ? '0 : r_pos;
    assign skip_dec  = r_skip - 8'd1;
    assign shift_hit = (r_byte & SHIFT_MASK) == SHIFT_CODE;
    assign act_new   = shift_hit ? r_byte[2:0] & CODESET_MASK[2:0] : r_active;
    assign lock_new  = (shift_hit && ((r_byte & NONLOCK_BIT) == 8'h00)) ? act_new : r_locked;
    assign cs_match  = act_new == r_scs;

    always_comb begin
        n_phase  = r_phase;
        n_skip   = r_skip;
        n_active = r_active;
        n_locked = r_locked;
        n_pos    = r_pos;
        n_sie    = r_sie;
        n_scs    = r_scs;
        have     = 1'b0;
        outcome  = OUT_FOUND;
        offset   = '0;

        unique case (r_phase)
            PH_DISC: begin
                n_sie    = r_wie;
                n_scs    = r_wcs;
                n_active = 3'd0;
                n_locked = 3'd0;
                n_phase  = PH_CRLEN;
            end
            PH_CRLEN: begin
                n_skip  = r_byte & CRLEN_MASK;
                n_phase = ((r_byte & CRLEN_MASK) != 8'h00) ? PH_CRREF : PH_MTYPE;
            end
            PH_CRREF: begin
                n_skip = skip_dec;
                if (skip_dec == 8'd0) begin
                    n_phase = PH_MTYPE;
                end
            end
            PH_MTYPE: begin
                n_phase = PH_IDENT;
            end
            PH_IDENT: begin
                n_active = act_new;
                n_locked = lock_new;
                if ((r_byte & SINGLE_BIT) == 8'h00) begin
                    if (cs_match && r_byte == r_sie) begin
                        have    = 1'b1;
                        outcome = OUT_FOUND;
                        offset  = pos_cur;
                    end else if (cs_match && r_byte > r_sie) begin
                        have    = 1'b1;
                        outcome = OUT_PASSED;
                    end else begin
                        n_active = lock_new;
                        n_phase  = PH_LEN;
                    end
                end
            end
            PH_LEN: begin
                n_skip  = r_byte;
                n_phase = (r_byte != 8'd0) ? PH_BODY : PH_IDENT;
            end
            PH_BODY: begin
                n_skip = skip_dec;
                if (skip_dec == 8'd0) begin
                    n_phase = PH_IDENT;
                end
            end
            PH_IDLE: begin
            end
            default: begin
                n_phase = PH_DISC;
            end
        endcase

        if (r_phase != PH_IDLE) begin
            if (!have && r_last) begin
                have    = 1'b1;
                outcome = OUT_END;
            end
            n_pos = (pos_cur < POS_CAP) ? pos_cur + 1'b1 : pos_cur;
            if (have && !r_last) begin
                n_phase = PH_IDLE;
            end
        end

        // last octet closes the message: start over
        if (r_last && (have || r_phase == PH_IDLE)) begin
            n_phase  = PH_DISC;
            n_skip   = 8'd0;
            n_active = 3'd0;
            n_locked = 3'd0;
            n_pos    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_DISC;
            r_skip   <= 8'd0;
            r_active <= 3'd0;
            r_locked <= 3'd0;
            r_pos    <= '0;
            r_sie    <= 8'd0;
            r_scs    <= 3'd0;
        end else if (advance) begin
            r_phase  <= n_phase;
            r_skip   <= n_skip;
            r_active <= n_active;
            r_locked <= n_locked;
            r_pos    <= n_pos;
            r_sie    <= n_sie;
            r_scs    <= n_scs;
        end
    end

    assign o_req.load        = advance && have;
    assign o_req.res.outcome = outcome;
    assign o_req.res.offset  = offset;

endmodule

>>> rtl/core/ief_result_reg.sv
// -----------------------------------------------------------------------------
// ief_result_reg
// Output register holding one search result until the sink takes it.
// -----------------------------------------------------------------------------
module ief_result_reg
    import ief_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_result_req   i_req,
    output logic          o_space,
    ief_out_if.source     o_out
);

    logic    r_valid;
    t_result r_res;

    assign o_space = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_req.load;
        end
        if (o_space && i_req.load) begin
            r_res <= i_req.res;
        end
    end

    assign o_out.valid     = r_valid;
    assign o_out.outcome   = r_res.outcome;
    assign o_out.ie_offset = r_res.offset;

endmodule

>>> rtl/core/isdn_info_element_finder.sv
// -----------------------------------------------------------------------------
// isdn_info_element_finder
// Walks a signalling message octet by octet and reports whether one
// information element is present in the wanted codeset, and where.
// -----------------------------------------------------------------------------
//   channel  | dir | modport | payload
//   ---------+-----+---------+-----------------------------------------------
//   i_in     | in  | sink    | msg_byte, last_byte, wanted_ie, wanted_codeset
//   o_out    | out | source  | outcome, ie_offset (0..511)
//
// Each octet enters the input register as one request, the parse logic
// decides it against the stored phase and codeset state, and any result
// lands in the output register on the same edge that advances the phase.
// Throughput is one octet per cycle while the result register is not stalled.
// Reset (i_rst_n low, synchronous) returns to the discriminator phase.
// A stalled result register holds the parse stage; i_in.ready drops only
// while both the input register and the result register are full.
// -----------------------------------------------------------------------------
`include "isdn_info_element_finder_defines.svh"

module isdn_info_element_finder
    import ief_pkg::*;
#(
    parameter int MaxMsgBytes = DEF_MAX_MSG_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ief_in_if.sink     i_in,
    ief_out_if.source  o_out
);

    t_result_req req;
    logic        space;

    // Parse stage: register the request, advance the message walk.
    ief_parser #(
        .MaxMsgBytes (MaxMsgBytes)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_space (space),
        .o_req   (req)
    );

    // Result stage: hold the outcome until the sink takes it.
    ief_result_reg u_result (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_space (space),
        .o_out   (o_out)
    );

    // A found element sits past discriminator, call-reference length and
    // message type, so its offset is never below three.
    `IEF_ASSERT_NOW(a_found_offset, i_clk, i_rst_n, o_out.valid && o_out.outcome == OUT_FOUND, o_out.ie_offset >= 9'd3, "found element reported inside the message header")

    // Offset carries meaning only for a found element.
    `IEF_ASSERT_NOW(a_other_offset, i_clk, i_rst_n, o_out.valid && o_out.outcome != OUT_FOUND, o_out.ie_offset == 9'd0, "nonzero offset on a passed or end-of-message result")

    // Back-pressure on the input comes only from a stalled result.
    `IEF_ASSERT_NOW(a_stall_source, i_clk, i_rst_n, !i_in.ready, o_out.valid && !o_out.ready, "input stalled without a stalled result")

endmodule
